/* rtl/fsic_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsic_pkg
// Shared types and constants of the first-seen index compactor.
// ----------------------------------------------------------------------------
package fsic_pkg;

	localparam int SRC_W       = 16;
	localparam int LOCAL_W     = 12;
	localparam int POOL_W      = 13;
	localparam int CFG_W       = 13;
	localparam int POOL_CAP    = 4096;
	localparam int VERTEX_COUNT_RST = 4096;
	localparam int CLOSE_MIN   = 2;
	localparam int RING_W      = 2;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [SRC_W-1:0] source_index;
		logic             ring_last;
		logic             geometry_start;
		logic             out_of_bounds;
	} item_t;

	typedef struct packed {
		logic [LOCAL_W-1:0] local_index;
		logic               new_entry;
		logic [LOCAL_W-1:0] fetch_index;
		logic               ring_end;
		logic               error;
		logic [POOL_W-1:0]  pool_size;
	} result_t;

endpackage
`default_nettype wire

/* rtl/fsic_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsic_in_if
// Input channel: one source vertex index per transaction.
// ----------------------------------------------------------------------------
interface fsic_in_if;
	import fsic_pkg::*;

	logic             valid;
	logic             ready;
	logic [SRC_W-1:0] source_index;
	logic             ring_last;
	logic             geometry_start;

	modport source (output valid, output source_index, output ring_last,
		output geometry_start, input ready);
	modport sink (input valid, input source_index, input ring_last,
		input geometry_start, output ready);
endinterface
`default_nettype wire

/* rtl/fsic_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsic_out_if
// Result channel: one compacted index per transaction.
// ----------------------------------------------------------------------------
interface fsic_out_if;
	import fsic_pkg::*;

	logic               valid;
	logic               ready;
	logic [LOCAL_W-1:0] local_index;
	logic               new_entry;
	logic [LOCAL_W-1:0] fetch_index;
	logic               ring_end;
	logic               error;
	logic [POOL_W-1:0]  pool_size;

	modport source (output valid, output local_index, output new_entry,
		output fetch_index, output ring_end, output error, output pool_size,
		input ready);
	modport sink (input valid, input local_index, input new_entry,
		input fetch_index, input ring_end, input error, input pool_size,
		output ready);
endinterface
`default_nettype wire

/* rtl/first_seen_index_compactor.sv */
// A result enters its output register after its item has passed the queue, the pop, the seen
// read, the pool read and the decide step; a flush or an output stall delays it further.
// The back end takes a new item only when idle, once the results of the last are sent; the
// 4-entry queue takes one item a cycle while it has room.
// Reset clears control state and sets vertex_count to 4096; the seen table needs
// no clearing pass, its entries are checked against the pool fill count.
`default_nettype none
// ----------------------------------------------------------------------------
// first_seen_index_compactor
// Maps source vertex indices to dense pool indices in first-seen order.
// ----------------------------------------------------------------------------
module first_seen_index_compactor #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [fsic_pkg::CFG_W-1:0] cfg_wr_data,
	fsic_in_if.sink                    items,
	fsic_out_if.source                 results
);
	import fsic_pkg::*;

	logic [CFG_W-1:0] vertex_count_q;
	logic             q_full;
	logic             push_valid;
	item_t            push_item;
	logic             pop_valid;
	item_t            pop_item;
	logic             pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CFG_W'(VERTEX_COUNT_RST);
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	fsic_front #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_front (
		.items        (items),
		.vertex_count (vertex_count_q),
		.q_full       (q_full),
		.push_valid   (push_valid),
		.push_item    (push_item)
	);

	fsic_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	fsic_back #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_item  (pop_item),
		.q_ready (pop_ready),
		.results (results)
	);
endmodule
`default_nettype wire

/* rtl/fsic_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsic_front
// Accepts input transactions and tags each with its bounds check.
// ----------------------------------------------------------------------------
module fsic_front #(
	parameter int MAX_VERTICES = 4096
) (
	fsic_in_if.sink                    items,
	input  logic [fsic_pkg::CFG_W-1:0] vertex_count,
	input  logic                       q_full,
	output logic                       push_valid,
	output fsic_pkg::item_t            push_item
);
	import fsic_pkg::*;

	logic oob_count;
	logic oob_max;

	assign oob_count = items.source_index >= {{(SRC_W-CFG_W){1'b0}}, vertex_count};
	assign oob_max   = {1'b0, items.source_index} >= (SRC_W+1)'(MAX_VERTICES);

	assign items.ready = !q_full;
	assign push_valid  = items.valid && !q_full;

	assign push_item.source_index   = items.source_index;
	assign push_item.ring_last      = items.ring_last;
	assign push_item.geometry_start = items.geometry_start;
	assign push_item.out_of_bounds  = oob_count || oob_max;
endmodule
`default_nettype wire

/* rtl/fsic_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsic_queue
// Short FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module fsic_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  fsic_pkg::item_t push_item,
	output logic            full,
	output logic            pop_valid,
	output fsic_pkg::item_t pop_item,
	input  logic            pop_ready
);
	import fsic_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item  = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/fsic_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsic_back
// Seen-table lookup, pool allocation, ring closure and result emission.
// ----------------------------------------------------------------------------
module fsic_back #(
	parameter int MAX_VERTICES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  fsic_pkg::item_t q_item,
	output logic            q_ready,
	fsic_out_if.source      results
);
	import fsic_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLUSH,
		S_CHECK,
		S_LOOK,
		S_DECIDE,
		S_EMIT
	} state_t;

	state_t              state_q;
	item_t               it_q;
	logic [POOL_W-1:0]   pool_count_q;
	logic [LOCAL_W-1:0]  ring_first_q;
	logic [RING_W-1:0]   ring_len_q;
	logic                held_valid_q;
	result_t             held_q;
	logic                abort_q;
	result_t             e0_q;
	result_t             e1_q;
	logic [1:0]          emit_cnt_q;
	logic                out_v_q;
	result_t             out_q;

	logic [LOCAL_W-1:0]  seen_local [MAX_VERTICES];
	logic [AW-1:0]       pool_src [POOL_CAP];
	logic [LOCAL_W-1:0]  seen_rd_q;
	logic [AW-1:0]       pool_rd_q;

	logic [AW-1:0]       addr;
	logic                hit;
	logic                full;
	logic                mem_we;
	logic [LOCAL_W-1:0]  dec_local;
	logic [POOL_W-1:0]   pool_next;
	logic [LOCAL_W-1:0]  first_eff;
	logic [RING_W-1:0]   ring_next;
	logic                closes;
	logic                out_free;
	logic                out_load;
	result_t             cur;
	result_t             held_end;
	result_t             d0;
	result_t             d1;
	logic [1:0]          dn;

	function automatic result_t mk_err(input logic [POOL_W-1:0] pool);
		result_t r;
		r             = '0;
		r.error       = 1'b1;
		r.pool_size   = pool;
		return r;
	endfunction

	assign addr      = it_q.source_index[AW-1:0];
	assign hit       = ({1'b0, seen_rd_q} < pool_count_q) && (pool_rd_q == addr);
	assign full      = !hit && (pool_count_q >= POOL_W'(POOL_CAP));
	assign dec_local = hit ? seen_rd_q : pool_count_q[LOCAL_W-1:0];
	assign pool_next = pool_count_q + {{(POOL_W-1){1'b0}}, !hit};
	assign first_eff = (ring_len_q == '0) ? dec_local : ring_first_q;
	assign ring_next = (ring_len_q == '1) ? ring_len_q : ring_len_q + RING_W'(1);
	assign closes    = it_q.ring_last && (ring_len_q >= RING_W'(CLOSE_MIN))
		&& (dec_local == first_eff) && held_valid_q;
	assign mem_we    = (state_q == S_DECIDE) && !hit && !full;
	assign out_free  = !out_v_q || results.ready;
	assign out_load  = out_free && ((state_q == S_FLUSH) || (state_q == S_EMIT));
	assign q_ready   = state_q == S_IDLE;

	always_comb begin
		cur             = '0;
		cur.local_index = dec_local;
		cur.new_entry   = !hit;
		cur.fetch_index = it_q.source_index[LOCAL_W-1:0];
		cur.pool_size   = pool_next;
		held_end          = held_q;
		held_end.ring_end = 1'b1;
		d0 = held_q;
		d1 = cur;
		dn = 2'd0;
		if (it_q.ring_last) begin
			d1.ring_end = 1'b1;
			if (closes) begin
				d0 = held_end;
				dn = 2'd1;
			end else if (held_valid_q) begin
				dn = 2'd2;
			end else begin
				d0 = d1;
				dn = 2'd1;
			end
		end else if (held_valid_q) begin
			dn = 2'd1;
		end
	end

	// seen table and pool source list; entries count only below the pool fill
	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_local[addr] <= dec_local;
		end
		seen_rd_q <= seen_local[addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pool_src[dec_local] <= addr;
		end
		pool_rd_q <= pool_src[seen_rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_count_q <= '0;
			ring_first_q <= '0;
			ring_len_q   <= '0;
			held_valid_q <= 1'b0;
			abort_q      <= 1'b0;
			emit_cnt_q   <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q <= q_item;
						if (q_item.geometry_start && held_valid_q) begin
							state_q <= S_FLUSH;
						end else begin
							if (q_item.geometry_start) begin
								pool_count_q <= '0;
								ring_first_q <= '0;
								ring_len_q   <= '0;
								abort_q      <= 1'b0;
							end
							state_q <= S_CHECK;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_q        <= held_end;
						pool_count_q <= '0;
						ring_first_q <= '0;
						ring_len_q   <= '0;
						held_valid_q <= 1'b0;
						abort_q      <= 1'b0;
						state_q      <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (abort_q) begin
						state_q <= S_IDLE;
					end else if (it_q.out_of_bounds) begin
						e0_q         <= mk_err(pool_count_q);
						emit_cnt_q   <= 2'd1;
						held_valid_q <= 1'b0;
						ring_len_q   <= '0;
						abort_q      <= 1'b1;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (full) begin
						e0_q         <= mk_err(pool_count_q);
						emit_cnt_q   <= 2'd1;
						held_valid_q <= 1'b0;
						ring_len_q   <= '0;
						abort_q      <= 1'b1;
						state_q      <= S_EMIT;
					end else begin
						pool_count_q <= pool_next;
						if (ring_len_q == '0) begin
							ring_first_q <= dec_local;
						end
						if (it_q.ring_last) begin
							held_valid_q <= 1'b0;
							ring_len_q   <= '0;
						end else begin
							held_q       <= cur;
							held_valid_q <= 1'b1;
							ring_len_q   <= ring_next;
						end
						e0_q       <= d0;
						e1_q       <= d1;
						emit_cnt_q <= dn;
						state_q    <= (dn == 2'd0) ? S_IDLE : S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q      <= e0_q;
						e0_q       <= e1_q;
						emit_cnt_q <= emit_cnt_q - 2'd1;
						if (emit_cnt_q == 2'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid       = out_v_q;
	assign results.local_index = out_q.local_index;
	assign results.new_entry   = out_q.new_entry;
	assign results.fetch_index = out_q.fetch_index;
	assign results.ring_end    = out_q.ring_end;
	assign results.error       = out_q.error;
	assign results.pool_size   = out_q.pool_size;

`ifndef SYNTHESIS
	a_pool_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pool_count_q <= POOL_W'(POOL_CAP))
		else $error("pool count beyond capacity");

	a_held_ring: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (ring_len_q != '0))
		else $error("held result outside a ring");

	a_abort_held: assert property (@(posedge clk) disable iff (!arst_n)
		abort_q && (state_q == S_IDLE) |-> !held_valid_q)
		else $error("held result in aborted geometry");

	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (emit_cnt_q != 2'd0))
		else $error("emit state with nothing to send");

	a_new_pool: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.new_entry |->
			(({1'b0, out_q.local_index} + POOL_W'(1)) == out_q.pool_size))
		else $error("new entry not at pool tail");
`endif
endmodule
`default_nettype wire
